// ===== hw/rtl/gwdm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwdm_pkg
// Shared types and constants of the grid word direction matcher.
// ----------------------------------------------------------------------------
package gwdm_pkg;

	// Item modes.
	localparam logic [1:0] MODE_GRID = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_TEST = 2'd2;
	localparam logic [1:0] MODE_NOP  = 2'd3;

	// Configuration register indexes and reset values.
	localparam logic CFG_GRID_ROWS = 1'b0;
	localparam logic CFG_GRID_COLS = 1'b1;
	localparam logic [6:0] GRID_ROWS_RESET = 7'd16;
	localparam logic [6:0] GRID_COLS_RESET = 7'd16;

	// Directions: bit order of the hit mask.
	localparam int NUM_DIRS = 6;
	localparam int DIR_W = 3;
	localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(NUM_DIRS - 1);

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_INC,
		STEP_DEC
	} step_t;

	// right, down, down-right, left, up, up-left
	localparam step_t ROW_STEP [NUM_DIRS] = '{STEP_NONE, STEP_INC, STEP_INC,
		STEP_NONE, STEP_DEC, STEP_DEC};
	localparam step_t COL_STEP [NUM_DIRS] = '{STEP_INC, STEP_NONE, STEP_INC,
		STEP_DEC, STEP_NONE, STEP_DEC};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic grid_write;
		logic word_write;
		logic start_test;
		logic dir_init;
		logic step;
		logic next_dir;
		logic mark_hit;
		logic set_all;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic in_area;
		logic len_zero;
		logic end_ok;
		logic issue_done;
		logic cmp_valid;
		logic cmp_match;
		logic last_dir;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/gwdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gwdm_ctrl
// Sequencer of the matcher: takes items, walks the six directions, hands
// the finished mask to the output register.
// ----------------------------------------------------------------------------
module gwdm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           mode,
	output logic                 in_ready,
	input  gwdm_pkg::dp_status_t status,
	output gwdm_pkg::dp_cmd_t    cmd
);
	import gwdm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && mode == MODE_TEST) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (!status.in_area || status.len_zero) begin
					state_d = ST_DONE;
				end else if (status.end_ok) begin
					state_d = ST_RUN;
				end else if (status.last_dir) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_RUN: begin
				if ((status.cmp_valid && !status.cmp_match) || status.issue_done) begin
					state_d = status.last_dir ? ST_DONE : ST_CHECK;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.grid_write = in_valid && mode == MODE_GRID;
				cmd.word_write = in_valid && mode == MODE_WORD;
				cmd.start_test = in_valid && mode == MODE_TEST;
			end
			ST_CHECK: begin
				cmd.dir_init = 1'b1;
				priority if (!status.in_area) begin
					cmd.set_all = 1'b0;
				end else if (status.len_zero) begin
					cmd.set_all = 1'b1;
				end else if (!status.end_ok) begin
					cmd.next_dir = 1'b1;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				priority if (status.cmp_valid && !status.cmp_match) begin
					cmd.next_dir = 1'b1;
				end else if (status.issue_done) begin
					cmd.next_dir = 1'b1;
					cmd.mark_hit = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.load_out = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/gwdm_datapath.sv =====
// ----------------------------------------------------------------------------
// gwdm_datapath
// Grid and word memories, configuration registers, walk counters, letter
// compare, hit mask and the output register.
// ----------------------------------------------------------------------------
module gwdm_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_WORD = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [6:0]           cfg_data,
	input  logic [5:0]           row,
	input  logic [5:0]           col,
	input  logic [7:0]           letter,
	input  logic [5:0]           word_pos,
	input  logic                 word_last,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [5:0]           hit_mask,
	output logic [5:0]           start_row,
	output logic [5:0]           start_col,
	input  gwdm_pkg::dp_cmd_t    cmd,
	output gwdm_pkg::dp_status_t status
);
	import gwdm_pkg::*;

	localparam int GD  = MAX_ROWS * MAX_COLS;
	localparam int AW  = (GD > 1) ? $clog2(GD) : 1;
	localparam int AXW = AW + 9;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
	localparam int LW  = $clog2(MAX_WORD + 1);
	localparam int BW  = ((LW > 8) ? LW : 8) + 2;

	logic [7:0] grid_mem [GD];
	logic [7:0] word_mem [MAX_WORD];

	logic [6:0]     grid_rows_q;
	logic [6:0]     grid_cols_q;
	logic [LW-1:0]  word_length_q;
	logic [5:0]     test_row_q;
	logic [5:0]     test_col_q;
	logic [DIR_W-1:0] dir_q;
	logic [RW-1:0]  pr_q;
	logic [CW-1:0]  pc_q;
	logic [LW-1:0]  k_q;
	logic [5:0]     mask_q;
	logic           cmp_valid_s1;
	logic [7:0]     grid_rd_s1;
	logic [7:0]     word_rd_s1;
	logic           out_valid_q;
	logic [5:0]     hit_mask_q;
	logic [5:0]     start_row_q;
	logic [5:0]     start_col_q;

	logic [BW-1:0] eff_rows;
	logic [BW-1:0] eff_cols;
	logic [BW-1:0] span;
	logic          grid_wr_ok;
	logic          word_wr_ok;
	logic          issue;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	function automatic logic axis_ok(step_t st, logic [BW-1:0] s, logic [BW-1:0] sp,
			logic [BW-1:0] lim);
		logic ok;
		unique case (st)
			STEP_NONE: ok = 1'b1;
			STEP_INC:  ok = (s + sp) < lim;
			STEP_DEC:  ok = s >= sp;
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

	assign eff_rows = (BW'(grid_rows_q) > BW'(MAX_ROWS)) ? BW'(MAX_ROWS) : BW'(grid_rows_q);
	assign eff_cols = (BW'(grid_cols_q) > BW'(MAX_COLS)) ? BW'(MAX_COLS) : BW'(grid_cols_q);
	assign span     = BW'(word_length_q) - BW'(1);

	assign grid_wr_ok = (BW'(row) < BW'(MAX_ROWS)) && (BW'(col) < BW'(MAX_COLS));
	assign word_wr_ok = BW'(word_pos) < BW'(MAX_WORD);
	assign wr_addr = AW'(AXW'(row) * AXW'(MAX_COLS) + AXW'(col));
	assign rd_addr = AW'(AXW'(pr_q) * AXW'(MAX_COLS) + AXW'(pc_q));
	assign issue   = cmd.step && (k_q != word_length_q);

	always_comb begin
		status.in_area    = (BW'(test_row_q) < eff_rows) && (BW'(test_col_q) < eff_cols);
		status.len_zero   = word_length_q == '0;
		status.end_ok     = axis_ok(ROW_STEP[dir_q], BW'(test_row_q), span, eff_rows) &&
			axis_ok(COL_STEP[dir_q], BW'(test_col_q), span, eff_cols);
		status.issue_done = k_q == word_length_q;
		status.cmp_valid  = cmp_valid_s1;
		status.cmp_match  = grid_rd_s1 == word_rd_s1;
		status.last_dir   = dir_q == LAST_DIR;
		status.out_free   = !out_valid_q || out_ready;
	end

	// Memories.
	always_ff @(posedge clk) begin
		if (cmd.grid_write && grid_wr_ok) begin
			grid_mem[wr_addr] <= letter;
		end
		if (issue) begin
			grid_rd_s1 <= grid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.word_write && word_wr_ok) begin
			word_mem[KW'(word_pos)] <= letter;
		end
		if (issue) begin
			word_rd_s1 <= word_mem[k_q[KW-1:0]];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= GRID_ROWS_RESET;
			grid_cols_q   <= GRID_COLS_RESET;
			word_length_q <= '0;
			cmp_valid_s1  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_GRID_ROWS) begin
				grid_rows_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_GRID_COLS) begin
				grid_cols_q <= cfg_data;
			end
			if (cmd.word_write && word_wr_ok && word_last) begin
				word_length_q <= LW'(word_pos) + LW'(1);
			end
			if (cmd.dir_init) begin
				cmp_valid_s1 <= 1'b0;
			end else if (cmd.step) begin
				cmp_valid_s1 <= issue;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk state and result.
	always_ff @(posedge clk) begin
		if (cmd.start_test) begin
			test_row_q <= row;
			test_col_q <= col;
			dir_q      <= '0;
			mask_q     <= '0;
		end
		if (cmd.dir_init) begin
			pr_q <= RW'(test_row_q);
			pc_q <= CW'(test_col_q);
			k_q  <= '0;
		end else if (issue) begin
			k_q <= k_q + LW'(1);
			unique case (ROW_STEP[dir_q])
				STEP_INC: pr_q <= pr_q + RW'(1);
				STEP_DEC: pr_q <= pr_q - RW'(1);
				default:  pr_q <= pr_q;
			endcase
			unique case (COL_STEP[dir_q])
				STEP_INC: pc_q <= pc_q + CW'(1);
				STEP_DEC: pc_q <= pc_q - CW'(1);
				default:  pc_q <= pc_q;
			endcase
		end
		if (cmd.set_all) begin
			mask_q <= '1;
		end else if (cmd.mark_hit) begin
			mask_q[dir_q] <= 1'b1;
		end
		if (cmd.next_dir) begin
			dir_q <= dir_q + DIR_W'(1);
		end
		if (cmd.load_out) begin
			hit_mask_q  <= mask_q;
			start_row_q <= test_row_q;
			start_col_q <= test_col_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_mask  = hit_mask_q;
	assign start_row = start_row_q;
	assign start_col = start_col_q;

endmodule

// ===== hw/rtl/grid_word_direction_matcher.sv =====
// ----------------------------------------------------------------------------
// grid_word_direction_matcher
// Holds a letter grid and one word and reports, for a tested start cell, in
// which of six directions the word lies in the grid.
//
// The input channel (in_valid/in_ready) carries one item per transfer. Grid
// and word letter writes leave the block idle, so they can follow each other
// in consecutive cycles. A test transfer starts a walk; the block drops
// in_ready until the result is placed in the output register. In each of
// the six directions the walk runs an end-of-word bounds check and, if the
// word fits, reads one grid letter and one word letter per cycle through
// the single read port of each memory. A mismatch ends a direction early.
// A start cell outside the grid area in use or an empty word ends the test
// at the first check, with no letters read.
// The output channel (out_valid/out_ready) is fed from a register: while a
// result waits, further write items are still taken; a following test walks
// all directions and then waits for the receiver before it hands over.
// Reset clears the word length and sets both grid sizes to 16. The grid and
// word memories are not cleared; configuration is written through cfg_we.
// ----------------------------------------------------------------------------
module grid_word_direction_matcher #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_WORD = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [5:0] row,
	input  logic [5:0] col,
	input  logic [7:0] letter,
	input  logic [5:0] word_pos,
	input  logic       word_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] hit_mask,
	output logic [5:0] start_row,
	output logic [5:0] start_col
);
	import gwdm_pkg::*;

	// Commands from the sequencer and status back from the datapath are the
	// only connection between the two halves.
	dp_cmd_t    cmd;
	dp_status_t status;

	gwdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds both memories; the grid is addressed row-major with
	// MAX_COLS entries per row, so the grid sizes only limit the area tested.
	gwdm_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_WORD (MAX_WORD)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row       (row),
		.col       (col),
		.letter    (letter),
		.word_pos  (word_pos),
		.word_last (word_last),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.hit_mask  (hit_mask),
		.start_row (start_row),
		.start_col (start_col),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ===== hw/rtl/gwdm_checker.sv =====
// ----------------------------------------------------------------------------
// gwdm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module gwdm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] hit_mask,
	input logic [5:0] start_row,
	input logic [5:0] start_col
);
	import gwdm_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hit_mask) && $stable(start_row) &&
		$stable(start_col))
		else $error("result payload changed while stalled");

	// A test transfer starts a walk that blocks the input.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_TEST |=> !in_ready)
		else $error("input still ready after a test transfer");

	// Write and idle transfers finish in their own cycle.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode != MODE_TEST |=> in_ready)
		else $error("input blocked after a write transfer");

	// A new result only appears at the end of a walk.
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a walk");

endmodule

bind grid_word_direction_matcher gwdm_checker u_gwdm_checker (.*);
